// File: rtl/q2e_pkg.sv
// Shared types, constants and helper functions for the quaternion to Euler converter.
package q2e_pkg;

    // Datapath widths
    localparam int CW         = 36;  // CORDIC x/y lanes
    localparam int AW         = 20;  // angle accumulator, 2^-16 rad
    localparam int SW         = 32;  // clamped asin numerator
    localparam int NW         = 62;  // square root remainder / root
    localparam int SQRT_STEPS = 31;  // root bits for a radicand below 2^62

    localparam logic signed [AW-1:0] HALF_PI_Q16     = 20'sd102944;
    localparam logic signed [15:0]   HALF_PI_Q12     = 16'sd6434;
    localparam logic [15:0]          THRESHOLD_RESET = 16'd32702;

    typedef enum logic [1:0] {
        POLE_NONE  = 2'd0,
        POLE_NORTH = 2'd1,
        POLE_SOUTH = 2'd2
    } pole_t;

    typedef struct packed {
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } quat_t;

    typedef struct packed {
        logic signed [15:0] heading;
        logic signed [15:0] attitude;
        logic signed [15:0] bank;
        logic [1:0]         pole_case;
    } euler_t;

    // Payload riding along with the square root cells
    typedef struct packed {
        logic signed [SW-1:0] s;
        logic signed [CW-1:0] hy;
        logic signed [CW-1:0] hx;
        logic signed [CW-1:0] by;
        logic signed [CW-1:0] bx;
        pole_t                pc;
        logic                 zero;
    } side_t;

    // One CORDIC lane
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [AW-1:0] acc;
        logic                 zero;
    } vec_t;

    typedef struct packed {
        pole_t pc;
        logic  zero;
    } tag_t;

    // atan(2^-i) in units of 2^-16 rad
    function automatic logic signed [AW-1:0] atan_q16(input int idx);
        case (idx)
            0:  return 20'sd51472;
            1:  return 20'sd30385;
            2:  return 20'sd16055;
            3:  return 20'sd8150;
            4:  return 20'sd4091;
            5:  return 20'sd2047;
            6:  return 20'sd1024;
            7:  return 20'sd512;
            8:  return 20'sd256;
            9:  return 20'sd128;
            10: return 20'sd64;
            11: return 20'sd32;
            12: return 20'sd16;
            13: return 20'sd8;
            14: return 20'sd4;
            15: return 20'sd2;
            16: return 20'sd1;
            default: return '0;
        endcase
    endfunction

    // Quadrant pre-rotation into the right half plane
    function automatic vec_t prerotate(input logic signed [CW-1:0] vy,
                                       input logic signed [CW-1:0] vx);
        vec_t v;
        v.zero = (vx == '0) && (vy == '0);
        v.x    = vx;
        v.y    = vy;
        v.acc  = '0;
        if (vx < 0) begin
            if (vy >= 0) begin
                v.x   = vy;
                v.y   = -vx;
                v.acc = HALF_PI_Q16;
            end else begin
                v.x   = -vy;
                v.y   = vx;
                v.acc = -HALF_PI_Q16;
            end
        end
        return v;
    endfunction

    // Q.16 to Q4.12, half away from zero
    function automatic logic signed [21:0] round_q12(input logic signed [21:0] v);
        logic signed [21:0] m;
        if (v >= 0) begin
            return (v + 22'sd8) >>> 4;
        end else begin
            m = -v;
            m = (m + 22'sd8) >>> 4;
            return -m;
        end
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
        if (v > 22'sd32767) return 16'sh7fff;
        if (v < -22'sd32768) return 16'sh8000;
        return v[15:0];
    endfunction

endpackage

// File: rtl/quaternion_to_euler.sv
// Top level of the quaternion to Euler angle converter.
// Converts one quaternion (Q1.15, not necessarily normalized) per transfer into heading,
// attitude and bank in Q4.12 radians plus a pole flag. The pipeline takes a new quaternion
// every cycle while the output is not stalled; each result passes through six front-end
// stages, the 31-cell square root chain that forms the asin cosine term, one quadrant
// pre-rotation stage, the CORDIC_STEPS cells of the three parallel CORDIC lanes and the
// output register. A stalled output holds the whole pipeline. pole_threshold is written
// through cfg_wr_en/cfg_wr_data and resets to 0.499.
module quaternion_to_euler #(
    parameter int CORDIC_STEPS = 16,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [15:0]      cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  q2e_pkg::quat_t   s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output q2e_pkg::euler_t  m_data
);

    localparam int LAT = 39 + CORDIC_STEPS;

    logic [15:0]      thr_reg;
    logic [LAT-1:0]   vld_reg;
    logic             en;

    logic [60:0]      rad;
    q2e_pkg::side_t   front_side;

    logic [q2e_pkg::NW-1:0] n_w    [0:q2e_pkg::SQRT_STEPS];
    logic [q2e_pkg::NW-1:0] r_w    [0:q2e_pkg::SQRT_STEPS];
    q2e_pkg::side_t         side_w [0:q2e_pkg::SQRT_STEPS];

    q2e_pkg::vec_t    lane_w [0:2][0:CORDIC_STEPS];
    q2e_pkg::tag_t    tag_reg [0:CORDIC_STEPS];
    q2e_pkg::euler_t  out_reg, out_next;

    q2e_pkg::side_t       sq_side;
    logic signed [q2e_pkg::CW-1:0] att_y, att_x;
    logic signed [21:0]   h_ang, a_ang, b_ang;

    assign en      = !m_valid || m_ready;
    assign s_ready = aresetn && en;
    assign m_valid = vld_reg[LAT-1];
    assign m_data  = out_reg;

    // threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= q2e_pkg::THRESHOLD_RESET;
        end else if (cfg_wr_en) begin
            thr_reg <= cfg_wr_data;
        end
    end

    // valid chain alongside the datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    q2e_front #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_front (
        .aclk (aclk),
        .en   (en),
        .thr  (thr_reg),
        .quat (s_data),
        .rad  (rad),
        .side (front_side)
    );

    assign n_w[0]    = {1'b0, rad};
    assign r_w[0]    = '0;
    assign side_w[0] = front_side;

    // square root chain, most significant root bit first
    for (genvar j = 0; j < q2e_pkg::SQRT_STEPS; j++) begin : g_sqrt
        q2e_sqrt_cell #(
            .K(q2e_pkg::SQRT_STEPS - 1 - j)
        ) u_cell (
            .aclk     (aclk),
            .en       (en),
            .n_in     (n_w[j]),
            .r_in     (r_w[j]),
            .side_in  (side_w[j]),
            .n_out    (n_w[j+1]),
            .r_out    (r_w[j+1]),
            .side_out (side_w[j+1])
        );
    end

    assign sq_side = side_w[q2e_pkg::SQRT_STEPS];
    assign att_y   = q2e_pkg::CW'(sq_side.s);
    assign att_x   = signed'(q2e_pkg::CW'(r_w[q2e_pkg::SQRT_STEPS][30:0]));

    // quadrant pre-rotation for the three lanes
    always_ff @(posedge aclk) begin
        if (en) begin
            lane_w[0][0] <= q2e_pkg::prerotate(sq_side.hy, sq_side.hx);
            lane_w[1][0] <= q2e_pkg::prerotate(att_y, att_x);
            lane_w[2][0] <= q2e_pkg::prerotate(sq_side.by, sq_side.bx);
            tag_reg[0]   <= '{pc: sq_side.pc, zero: sq_side.zero};
        end
    end

    // CORDIC lanes: heading, attitude, bank
    for (genvar ln = 0; ln < 3; ln++) begin : g_lane
        for (genvar st = 0; st < CORDIC_STEPS; st++) begin : g_step
            q2e_cordic_cell #(
                .STEP(st)
            ) u_cell (
                .aclk  (aclk),
                .en    (en),
                .v_in  (lane_w[ln][st]),
                .v_out (lane_w[ln][st+1])
            );
        end
    end

    for (genvar st = 0; st < CORDIC_STEPS; st++) begin : g_tag
        always_ff @(posedge aclk) begin
            if (en) begin
                tag_reg[st+1] <= tag_reg[st];
            end
        end
    end

    // final rounding, zero-norm and pole override and saturation
    always_comb begin
        h_ang = lane_w[0][CORDIC_STEPS].zero ? '0 : 22'(lane_w[0][CORDIC_STEPS].acc);
        a_ang = lane_w[1][CORDIC_STEPS].zero ? '0 : 22'(lane_w[1][CORDIC_STEPS].acc);
        b_ang = lane_w[2][CORDIC_STEPS].zero ? '0 : 22'(lane_w[2][CORDIC_STEPS].acc);
        out_next.heading   = q2e_pkg::sat16(q2e_pkg::round_q12(h_ang));
        out_next.attitude  = q2e_pkg::sat16(q2e_pkg::round_q12(a_ang));
        out_next.bank      = q2e_pkg::sat16(q2e_pkg::round_q12(b_ang));
        out_next.pole_case = tag_reg[CORDIC_STEPS].pc;
        if (tag_reg[CORDIC_STEPS].zero) begin
            out_next.heading   = '0;
            out_next.attitude  = '0;
            out_next.bank      = '0;
            out_next.pole_case = q2e_pkg::POLE_NONE;
        end else if (tag_reg[CORDIC_STEPS].pc == q2e_pkg::POLE_NORTH) begin
            out_next.heading  = q2e_pkg::sat16(q2e_pkg::round_q12(h_ang <<< 1));
            out_next.attitude = q2e_pkg::HALF_PI_Q12;
            out_next.bank     = '0;
        end else if (tag_reg[CORDIC_STEPS].pc == q2e_pkg::POLE_SOUTH) begin
            out_next.heading  = q2e_pkg::sat16(q2e_pkg::round_q12(-(h_ang <<< 1)));
            out_next.attitude = -q2e_pkg::HALF_PI_Q12;
            out_next.bank     = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

endmodule

// File: rtl/q2e_front.sv
// Front end: sample rescale, products, norm, pole tests and the asin radicand.
module q2e_front #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [15:0]          thr,
    input  q2e_pkg::quat_t       quat,
    output logic [60:0]          rad,
    output q2e_pkg::side_t       side
);

    localparam int SH_DN = (SAMPLE_WIDTH > 16) ? SAMPLE_WIDTH - 16 : 0;
    localparam int SH_UP = (SAMPLE_WIDTH < 16) ? 16 - SAMPLE_WIDTH : 0;

    function automatic logic signed [15:0] rescale(input logic [15:0] raw);
        if (SAMPLE_WIDTH > 16) return signed'(raw >> SH_DN);
        else return signed'(raw << SH_UP);
    endfunction

    function automatic logic signed [31:0] mul16(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
        logic signed [31:0] a32;
        logic signed [31:0] b32;
        a32 = a;
        b32 = b;
        return a32 * b32;
    endfunction

    // stage 1: samples
    logic signed [15:0] x1_reg, y1_reg, z1_reg, w1_reg;
    // stage 2: products
    logic signed [31:0] xx_reg, yy_reg, zz_reg, ww_reg;
    logic signed [31:0] xy_reg, zw_reg, yw_reg, xz_reg, xw_reg, yz_reg;
    logic signed [15:0] x2_reg, w2_reg;
    // stage 3: sums
    logic [33:0]                 unit3_reg;
    logic signed [32:0]          test3_reg;
    logic signed [q2e_pkg::CW-1:0] hy3_reg, hx3_reg, by3_reg, bx3_reg;
    logic signed [15:0]          x3_reg, w3_reg;
    // stage 4: threshold product and clamp
    logic [49:0]                 lim4_reg;
    logic signed [32:0]          test4_reg;
    logic [31:0]                 u4_reg;
    logic signed [q2e_pkg::SW-1:0] s4_reg;
    logic                        zero4_reg;
    logic signed [q2e_pkg::CW-1:0] hy4_reg, hx4_reg, by4_reg, bx4_reg;
    logic signed [15:0]          x4_reg, w4_reg;
    // stage 5: squares and pole decision
    logic [61:0]                 uu5_reg, ss5_reg;
    q2e_pkg::side_t              side5_reg;
    // stage 6: radicand
    logic [60:0]                 rad6_reg;
    q2e_pkg::side_t              side6_reg;

    logic signed [33:0] hy3_next, hx3_next, by3_next, bx3_next;
    logic signed [32:0] s4_full;
    logic signed [32:0] u4_s;
    logic signed [51:0] t52, lim52;
    logic [30:0]        s_mag;
    q2e_pkg::side_t     side5_next;

    // stage 3 sums
    always_comb begin
        hy3_next = 34'(yw_reg) - 34'(xz_reg);
        hy3_next = hy3_next <<< 1;
        by3_next = 34'(xw_reg) - 34'(yz_reg);
        by3_next = by3_next <<< 1;
        hx3_next = 34'(xx_reg) - 34'(yy_reg) - 34'(zz_reg) + 34'(ww_reg);
        bx3_next = 34'(yy_reg) - 34'(xx_reg) - 34'(zz_reg) + 34'(ww_reg);
    end

    // stage 4 clamp of the asin numerator to the quarter norm
    always_comb begin
        u4_s    = signed'({1'b0, unit3_reg[33:2]});
        s4_full = test3_reg >>> 1;
        if (s4_full > u4_s) s4_full = u4_s;
        if (s4_full < -u4_s) s4_full = -u4_s;
    end

    // stage 5 pole tests and heading lane select
    always_comb begin
        t52   = {{3{test4_reg[32]}}, test4_reg, 16'b0};
        lim52 = signed'({2'b00, lim4_reg});
        s_mag = s4_reg[q2e_pkg::SW-1] ? 31'(-s4_reg) : s4_reg[30:0];
        side5_next.s    = s4_reg;
        side5_next.by   = by4_reg;
        side5_next.bx   = bx4_reg;
        side5_next.zero = zero4_reg;
        side5_next.hy   = hy4_reg;
        side5_next.hx   = hx4_reg;
        side5_next.pc   = q2e_pkg::POLE_NONE;
        if (t52 > lim52) begin
            side5_next.pc = q2e_pkg::POLE_NORTH;
        end else if (t52 < -lim52) begin
            side5_next.pc = q2e_pkg::POLE_SOUTH;
        end
        if (side5_next.pc != q2e_pkg::POLE_NONE) begin
            side5_next.hy = {{4{x4_reg[15]}}, x4_reg, 16'b0};
            side5_next.hx = {{4{w4_reg[15]}}, w4_reg, 16'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_reg <= rescale(quat.quat_x);
            y1_reg <= rescale(quat.quat_y);
            z1_reg <= rescale(quat.quat_z);
            w1_reg <= rescale(quat.quat_w);

            xx_reg <= mul16(x1_reg, x1_reg);
            yy_reg <= mul16(y1_reg, y1_reg);
            zz_reg <= mul16(z1_reg, z1_reg);
            ww_reg <= mul16(w1_reg, w1_reg);
            xy_reg <= mul16(x1_reg, y1_reg);
            zw_reg <= mul16(z1_reg, w1_reg);
            yw_reg <= mul16(y1_reg, w1_reg);
            xz_reg <= mul16(x1_reg, z1_reg);
            xw_reg <= mul16(x1_reg, w1_reg);
            yz_reg <= mul16(y1_reg, z1_reg);
            x2_reg <= x1_reg;
            w2_reg <= w1_reg;

            unit3_reg <= 34'(unsigned'(xx_reg)) + 34'(unsigned'(yy_reg))
                       + 34'(unsigned'(zz_reg)) + 34'(unsigned'(ww_reg));
            test3_reg <= 33'(xy_reg) + 33'(zw_reg);
            hy3_reg   <= q2e_pkg::CW'(hy3_next);
            hx3_reg   <= q2e_pkg::CW'(hx3_next);
            by3_reg   <= q2e_pkg::CW'(by3_next);
            bx3_reg   <= q2e_pkg::CW'(bx3_next);
            x3_reg    <= x2_reg;
            w3_reg    <= w2_reg;

            lim4_reg  <= 50'(thr) * 50'(unit3_reg);
            test4_reg <= test3_reg;
            u4_reg    <= unit3_reg[33:2];
            s4_reg    <= q2e_pkg::SW'(s4_full);
            zero4_reg <= (unit3_reg == '0);
            hy4_reg   <= hy3_reg;
            hx4_reg   <= hx3_reg;
            by4_reg   <= by3_reg;
            bx4_reg   <= bx3_reg;
            x4_reg    <= x3_reg;
            w4_reg    <= w3_reg;

            uu5_reg   <= 62'(u4_reg[30:0]) * 62'(u4_reg[30:0]);
            ss5_reg   <= 62'(s_mag) * 62'(s_mag);
            side5_reg <= side5_next;

            rad6_reg  <= 61'(uu5_reg - ss5_reg);
            side6_reg <= side5_reg;
        end
    end

    assign rad  = rad6_reg;
    assign side = side6_reg;

endmodule

// File: rtl/q2e_sqrt_cell.sv
// One cell of the pipelined integer square root: resolves one root bit.
module q2e_sqrt_cell #(
    parameter int K = 0
) (
    input  logic                      aclk,
    input  logic                      en,
    input  logic [q2e_pkg::NW-1:0]    n_in,
    input  logic [q2e_pkg::NW-1:0]    r_in,
    input  q2e_pkg::side_t            side_in,
    output logic [q2e_pkg::NW-1:0]    n_out,
    output logic [q2e_pkg::NW-1:0]    r_out,
    output q2e_pkg::side_t            side_out
);

    localparam logic [q2e_pkg::NW-1:0] BIT_VAL = q2e_pkg::NW'(1) << (2 * K);

    logic [q2e_pkg::NW-1:0] n_reg, n_next;
    logic [q2e_pkg::NW-1:0] r_reg, r_next;
    q2e_pkg::side_t         side_reg;
    logic [q2e_pkg::NW-1:0] trial;

    // trial subtract of the next root bit
    always_comb begin
        trial  = r_in + BIT_VAL;
        n_next = n_in;
        r_next = r_in >> 1;
        if (n_in >= trial) begin
            n_next = n_in - trial;
            r_next = (r_in >> 1) + BIT_VAL;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg    <= n_next;
            r_reg    <= r_next;
            side_reg <= side_in;
        end
    end

    assign n_out    = n_reg;
    assign r_out    = r_reg;
    assign side_out = side_reg;

endmodule

// File: rtl/q2e_cordic_cell.sv
// One vectoring CORDIC micro-rotation with its angle accumulator.
module q2e_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic           aclk,
    input  logic           en,
    input  q2e_pkg::vec_t  v_in,
    output q2e_pkg::vec_t  v_out
);

    localparam logic signed [q2e_pkg::AW-1:0] ANGLE = q2e_pkg::atan_q16(STEP);

    q2e_pkg::vec_t v_reg, v_next;
    logic signed [q2e_pkg::CW-1:0] dx, dy;

    // rotate toward the x axis
    always_comb begin
        dx     = v_in.y >>> STEP;
        dy     = v_in.x >>> STEP;
        v_next = v_in;
        if (v_in.y > 0) begin
            v_next.x   = v_in.x + dx;
            v_next.y   = v_in.y - dy;
            v_next.acc = v_in.acc + ANGLE;
        end else begin
            v_next.x   = v_in.x - dx;
            v_next.y   = v_in.y + dy;
            v_next.acc = v_in.acc - ANGLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v_reg <= v_next;
        end
    end

    assign v_out = v_reg;

endmodule

// File: bench/quaternion_to_euler_test.sv
// Self-checking testbench for the quaternion to Euler angle converter.
`timescale 1ns / 1ps

module quaternion_to_euler_test;

    localparam int STEPS   = 16;
    localparam int LATENCY = 39 + STEPS;

    // Golden conversion of one quaternion plus the queue of pending angles
    class euler_scoreboard;
        q2e_pkg::euler_t pending[$];
        int     errors;
        logic [15:0] threshold;

        function new();
            errors    = 0;
            threshold = q2e_pkg::THRESHOLD_RESET;
        endfunction

        // floor shift of a signed value
        function longint shr(longint v, int s);
            return v >>> s;
        endfunction

        function longint round_angle(longint v);
            if (v >= 0) return (v + 8) >>> 4;
            return -(((-v) + 8) >>> 4);
        endfunction

        function logic [15:0] clip16(longint v);
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            return v[15:0];
        endfunction

        function longint root(longint n);
            longint r;
            longint b;
            r = 0;
            b = 64'sd1 <<< 62;
            while (b > n) b = b >>> 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >>> 1) + b;
                end else begin
                    r = r >>> 1;
                end
                b = b >>> 2;
            end
            return r;
        endfunction

        // vectoring CORDIC, result in 2^-16 rad
        function longint vec_angle(longint y, longint x);
            longint acc;
            longint t;
            longint dx;
            longint dy;
            acc = 0;
            if (x == 0 && y == 0) return 0;
            if (x < 0) begin
                if (y >= 0) begin
                    t = x; x = y; y = -t; acc = q2e_pkg::HALF_PI_Q16;
                end else begin
                    t = x; x = -y; y = t; acc = -q2e_pkg::HALF_PI_Q16;
                end
            end
            for (int i = 0; i < STEPS; i++) begin
                dx = shr(y, i);
                dy = shr(x, i);
                if (y > 0) begin
                    x += dx; y -= dy; acc += atan_step(i);
                end else begin
                    x -= dx; y += dy; acc -= atan_step(i);
                end
            end
            return acc;
        endfunction

        function longint atan_step(int i);
            longint tbl[17] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                                256, 128, 64, 32, 16, 8, 4, 2, 1};
            return (i < 17) ? tbl[i] : 0;
        endfunction

        function void note_quat(q2e_pkg::quat_t q);
            longint x, y, z, w, unit, tst, lim, h, a, b, u, s, c;
            q2e_pkg::euler_t e;
            x = q.quat_x; y = q.quat_y; z = q.quat_z; w = q.quat_w;
            unit = x*x + y*y + z*z + w*w;
            tst  = x*y + z*w;
            lim  = longint'(threshold) * unit;
            h = 0; a = 0; b = 0;
            e.pole_case = q2e_pkg::POLE_NONE;
            if (unit == 0) begin
                h = 0;
            end else if (tst * 65536 > lim) begin
                h = round_angle(2 * vec_angle(x * 65536, w * 65536));
                a = q2e_pkg::HALF_PI_Q12;
                e.pole_case = q2e_pkg::POLE_NORTH;
            end else if (tst * 65536 < -lim) begin
                h = round_angle(-2 * vec_angle(x * 65536, w * 65536));
                a = -q2e_pkg::HALF_PI_Q12;
                e.pole_case = q2e_pkg::POLE_SOUTH;
            end else begin
                u = unit >>> 2;
                s = shr(2 * tst, 2);
                if (s > u) s = u;
                if (s < -u) s = -u;
                c = root(u*u - s*s);
                h = round_angle(vec_angle(2*y*w - 2*x*z, x*x - y*y - z*z + w*w));
                a = round_angle(vec_angle(s, c));
                b = round_angle(vec_angle(2*x*w - 2*y*z, -x*x + y*y - z*z + w*w));
            end
            e.heading  = clip16(h);
            e.attitude = clip16(a);
            e.bank     = clip16(b);
            pending.push_back(e);
        endfunction

        function void check_angles(q2e_pkg::euler_t got);
            q2e_pkg::euler_t e;
            if (pending.size() == 0) begin
                $error("unexpected result transfer %h", got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.heading !== e.heading) begin
                $error("heading: expected %0d, actual %0d", e.heading, got.heading);
                errors++;
            end
            if (got.attitude !== e.attitude) begin
                $error("attitude: expected %0d, actual %0d", e.attitude, got.attitude);
                errors++;
            end
            if (got.bank !== e.bank) begin
                $error("bank: expected %0d, actual %0d", e.bank, got.bank);
                errors++;
            end
            if (got.pole_case !== e.pole_case) begin
                $error("pole_case: expected %0d, actual %0d", e.pole_case, got.pole_case);
                errors++;
            end
        endfunction
    endclass

    logic            aclk;
    logic            aresetn;
    logic            cfg_wr_en;
    logic [15:0]     cfg_wr_data;
    logic            s_valid;
    logic            s_ready;
    q2e_pkg::quat_t  s_data;
    logic            m_valid;
    logic            m_ready;
    q2e_pkg::euler_t m_data;

    euler_scoreboard sb;
    bit  calm;        // no idling in the last part
    int  hold_off;    // long receiver stall, in cycles

    quaternion_to_euler #(.CORDIC_STEPS(STEPS), .SAMPLE_WIDTH(16)) u_top (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        aclk = 1'b1; #6;
        aclk = 1'b0; #6;
    end

    // Guard against a hang
    initial begin
        #60ms;
        $display("quaternion_to_euler_test: done, errors");
        $finish;
    end

    // Receiver: random stalls, one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off > 0) begin
                m_ready <= 1'b0;
                repeat (hold_off) @(negedge aclk);
                hold_off = 0;
            end
            if (!calm && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // Result sampling
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_angles(m_data);
    end

    // Input transfer bookkeeping
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) sb.note_quat(s_data);
    end

    task automatic send_quat(q2e_pkg::quat_t q);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= q;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
    endtask

    task automatic set_threshold(logic [15:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.threshold = v;
    endtask

    function automatic logic [15:0] pick_comp();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'($signed($urandom_range(0, 16)) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    // Quaternion near a pole: x*y+z*w close to half the norm
    function automatic q2e_pkg::quat_t near_pole();
        q2e_pkg::quat_t q;
        logic [15:0] a, b;
        a = 16'($urandom_range(0, 23000));
        b = 16'($urandom_range(0, 23000));
        q.quat_x = a;
        q.quat_y = $urandom_range(0, 1) ? a : -a;
        q.quat_z = b;
        q.quat_w = (q.quat_y == a) ? b : -b;
        q.quat_y = q.quat_y + 16'($signed($urandom_range(0, 64)) - 32);
        return q;
    endfunction

    function automatic q2e_pkg::quat_t rand_quat();
        q2e_pkg::quat_t q;
        if ($urandom_range(0, 3) == 0) return near_pole();
        q.quat_x = pick_comp();
        q.quat_y = pick_comp();
        q.quat_z = pick_comp();
        q.quat_w = pick_comp();
        return q;
    endfunction

    initial begin
        logic [15:0] thr_list[5] = '{16'd0, 16'hffff, 16'd32768, 16'd1000, 16'd32702};
        sb          = new();
        calm        = 1'b0;
        hold_off    = 0;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_data      = '0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed: zero norm, extremes, both poles, clamped asin, axis cases
        send_quat('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
        send_quat('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
        send_quat('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
        send_quat('{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff});
        send_quat('{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000});
        send_quat('{16'sd23170, 16'sd23170, 16'sd0, 16'sd0});
        send_quat('{16'sd23170, -16'sd23170, 16'sd0, 16'sd0});
        send_quat('{16'sd0, 16'sd0, 16'sd23170, 16'sd23170});
        send_quat('{16'sd0, 16'sd0, 16'sd0, 16'sh8000});
        send_quat('{16'sh8000, 16'sd0, 16'sd0, 16'sd0});
        send_quat('{16'sd0, 16'sh7fff, 16'sd0, 16'sd0});
        send_quat('{16'sd0, 16'sd0, 16'sh7fff, 16'sd0});
        send_quat('{16'sd0, 16'sd0, 16'sd0, 16'sd1});
        send_quat('{-16'sd1, 16'sd0, 16'sd0, -16'sd1});
        send_quat('{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384});
        send_quat('{16'sd5, 16'sd5, -16'sd5, 16'sd5});
        drain();

        // Threshold zero: any nonzero test picks a pole by its sign
        set_threshold(16'd0);
        send_quat('{16'sd1, 16'sd1, 16'sd0, 16'sd0});
        send_quat('{16'sd1, -16'sd1, 16'sd0, 16'sd0});
        send_quat('{16'sd100, 16'sd0, 16'sd0, 16'sd50});
        drain();

        // Random phases across threshold settings
        foreach (thr_list[k]) begin
            set_threshold(k == 4 ? 16'($urandom) : thr_list[k]);
            for (int n = 0; n < 240; n++) send_quat(rand_quat());
            drain();
        end
        set_threshold(16'd32702);

        // Receiver stalls while the sender keeps offering
        hold_off = 200;
        for (int n = 0; n < 180; n++) send_quat(rand_quat());
        drain();

        // Final stretch with no idling
        calm = 1'b1;
        for (int n = 0; n < 260; n++) send_quat(rand_quat());
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("quaternion_to_euler_test: done, clean");
        end else begin
            $display("quaternion_to_euler_test: done, errors");
        end
        $finish;
    end
endmodule
